// File: rtl/uart_rsi_pkg.sv
// Shared constants and types of the UART register, status and interrupt unit.
package uart_rsi_pkg;

    // Bus access and line event codes carried in the input tuser field.
    localparam logic [2:0] ACT_READ_RX   = 3'd0;
    localparam logic [2:0] ACT_READ_STS  = 3'd1;
    localparam logic [2:0] ACT_WRITE_TX  = 3'd2;
    localparam logic [2:0] ACT_WRITE_CTL = 3'd3;
    localparam logic [2:0] ACT_RX_CHAR   = 3'd4;
    localparam logic [2:0] ACT_TX_DONE   = 3'd5;

    // Status register bit positions.
    localparam int STS_DA        = 0;
    localparam int STS_OE        = 1;
    localparam int STS_FE        = 3;
    localparam int STS_TSR_EMPTY = 6;
    localparam int STS_THR_EMPTY = 7;

    // Control register bit positions.
    localparam int CTL_IE         = 5;
    localparam int CTL_SEND_BREAK = 6;
    localparam int CTL_TR         = 7;

    localparam logic [7:0] TX_EMPTY_BITS = 8'hC0;
    localparam logic [7:0] RX_FLAG_BITS  = 8'h03;
    localparam logic [7:0] STATUS_RESET  = TX_EMPTY_BITS;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // One result transaction, packed from the lowest bit up as read_data first.
    typedef struct packed {
        logic       rxd_level;
        logic       break_out;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq;
        logic [7:0] read_data;
    } result_t;

endpackage

// File: rtl/uart_register_status_irq_unit.sv
// Top level of the UART register, status and interrupt unit.
//
// The unit models the CPU-visible registers of a classic UART. Each input
// transaction is one bus access or line event: s_tuser selects the action
// (read receive buffer, read status, write transmit holding, write control,
// character received, transmitter done), s_tdata carries the byte and the
// received-break flag. Every input transaction yields exactly one result
// transaction on the m_ channel with the read value, the interrupt level,
// a transmit start strobe and byte, the break output and the receive line.
//
// The register state updates in the cycle the input transaction is accepted;
// into an empty buffer the result appears on m_tvalid in the next cycle, and
// one transaction per cycle is sustained while each result is taken. The
// output side is a two-entry buffer (output register plus skid register), so
// when the receiver stalls one more input is still taken; s_tready drops only
// while both entries are full, and rises the cycle after m_tready returns.
//
// Reset (aresetn low at a rising edge of aclk) empties the output buffer,
// clears the receive buffer, control register, interrupt and pending THRE
// interrupt flags, and sets the status register to THRE and TSRE.
module uart_register_status_irq_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_in, [8] rx_break, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] read_data, [8] irq, [9] tx_valid,
                                   // [17:10] tx_byte, [18] break_out,
                                   // [19] rxd_level, [23:20] zero
);

    logic [7:0] rx_buffer_reg, rx_buffer_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] status_reg, status_next;
    logic       irq_reg, irq_next;
    logic       pend_reg, pend_next;

    uart_rsi_pkg::result_t main_reg, main_next;
    uart_rsi_pkg::result_t skid_reg, skid_next;
    logic                  main_valid_reg, main_valid_next;
    logic                  skid_valid_reg, skid_valid_next;

    uart_rsi_pkg::result_t result;
    logic                  accept;
    logic                  pop;
    logic [7:0]            data_in;
    logic                  rx_break;
    logic                  do_update;

    assign data_in  = s_tdata[7:0];
    assign rx_break = s_tdata[8];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = main_valid_reg;
    assign pop      = main_valid_reg && m_tready;
    assign m_tdata  = {{(uart_rsi_pkg::OUT_DATA_W - $bits(uart_rsi_pkg::result_t)){1'b0}},
                       main_reg};

    // Register semantics for one action. A status update recomputes the
    // interrupt level and latches a rising THRE edge as a pending interrupt.
    always_comb begin
        rx_buffer_next = rx_buffer_reg;
        control_next   = control_reg;
        status_next    = status_reg;
        irq_next       = irq_reg;
        pend_next      = pend_reg;
        do_update      = 1'b0;
        result         = '0;

        case (s_tuser)
            uart_rsi_pkg::ACT_READ_RX: begin
                status_next      = status_reg & ~uart_rsi_pkg::RX_FLAG_BITS;
                do_update        = 1'b1;
                result.read_data = rx_buffer_reg;
            end
            uart_rsi_pkg::ACT_READ_STS: begin
                pend_next = 1'b0;
                do_update = 1'b1;
                if (rx_break) begin
                    status_next[uart_rsi_pkg::STS_FE] = 1'b1;
                end
                result.read_data = status_next;
                // TSRE follows THRE only after the status has been read.
                if (status_next[uart_rsi_pkg::STS_THR_EMPTY]) begin
                    status_next[uart_rsi_pkg::STS_TSR_EMPTY] = 1'b1;
                end
            end
            uart_rsi_pkg::ACT_WRITE_TX: begin
                // The transmitter is held off while BREAK is set.
                if (!control_reg[uart_rsi_pkg::CTL_SEND_BREAK]) begin
                    pend_next       = 1'b0;
                    status_next     = status_reg & ~uart_rsi_pkg::TX_EMPTY_BITS;
                    do_update       = 1'b1;
                    result.tx_valid = 1'b1;
                    result.tx_byte  = data_in;
                end
            end
            uart_rsi_pkg::ACT_WRITE_CTL: begin
                if (data_in[uart_rsi_pkg::CTL_TR]) begin
                    // Transmit request: raise a THRE interrupt if it is empty.
                    if (status_reg[uart_rsi_pkg::STS_THR_EMPTY]) begin
                        pend_next = 1'b1;
                        do_update = 1'b1;
                    end
                    control_next[uart_rsi_pkg::CTL_TR] = 1'b1;
                end else begin
                    control_next = data_in;
                    do_update    = data_in[uart_rsi_pkg::CTL_IE]
                                   != control_reg[uart_rsi_pkg::CTL_IE];
                end
            end
            uart_rsi_pkg::ACT_RX_CHAR: begin
                rx_buffer_next = data_in;
                if (status_reg[uart_rsi_pkg::STS_DA]) begin
                    status_next[uart_rsi_pkg::STS_OE] = 1'b1;
                end else begin
                    status_next[uart_rsi_pkg::STS_DA] = 1'b1;
                end
                do_update = 1'b1;
            end
            uart_rsi_pkg::ACT_TX_DONE: begin
                if (!control_reg[uart_rsi_pkg::CTL_SEND_BREAK]) begin
                    status_next[uart_rsi_pkg::STS_THR_EMPTY] = 1'b1;
                    do_update = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_update) begin
            if (status_next[uart_rsi_pkg::STS_THR_EMPTY]
                    && !status_reg[uart_rsi_pkg::STS_THR_EMPTY]) begin
                pend_next = 1'b1;
            end
            irq_next = control_next[uart_rsi_pkg::CTL_IE]
                       && (status_next[uart_rsi_pkg::STS_DA] || pend_next);
        end

        result.irq       = irq_next;
        result.break_out = control_next[uart_rsi_pkg::CTL_SEND_BREAK];
        result.rxd_level = !rx_break;
    end

    // Two-entry output buffer: the skid entry fills only while the output
    // register holds a result the receiver has not taken.
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = result;
                main_valid_next = accept;
            end
        end else if (accept) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_buffer_reg  <= '0;
            control_reg    <= '0;
            status_reg     <= uart_rsi_pkg::STATUS_RESET;
            irq_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                rx_buffer_reg <= rx_buffer_next;
                control_reg   <= control_next;
                status_reg    <= status_next;
                irq_reg       <= irq_next;
                pend_reg      <= pend_next;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry is only ever occupied behind a held output register.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("skid entry full while output register empty");

    // TSRE is cleared together with THRE and set only while THRE is set.
    a_tsre_implies_thre: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg[uart_rsi_pkg::STS_TSR_EMPTY] |-> status_reg[uart_rsi_pkg::STS_THR_EMPTY])
        else $error("TSRE set while THRE clear");

    // The interrupt is gated by IE.
    a_irq_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        irq_reg |-> control_reg[uart_rsi_pkg::CTL_IE])
        else $error("interrupt raised with IE clear");

    // An item accepted into an empty buffer is presented in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !m_tvalid |=> m_tvalid)
        else $error("accepted transaction not presented on the output");

endmodule
